/* rtl/core/ivp_pkg.sv */
// ----------------------------------------------------------------------------
// ivp_pkg
// Types, register indexes, reset levels and mode codes shared by the
// input-voltage protection block.
// ----------------------------------------------------------------------------
package ivp_pkg;

	localparam int SAMPLE_W = 12;
	localparam int TICK_W   = 32;
	localparam int TIME_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_ON_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_LEVEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_LOW_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_HIGH_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WINDOW_MS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY_MS      = 3'd6;

	// register reset values
	localparam logic [SAMPLE_W-1:0] RST_OFF_LEVEL         = 12'd1700;
	localparam logic [SAMPLE_W-1:0] RST_STARTUP_ON_LEVEL  = 12'd1650;
	localparam logic [SAMPLE_W-1:0] RST_RESTORE_LEVEL     = 12'd2100;
	localparam logic [SAMPLE_W-1:0] RST_REDUCE_LOW_LEVEL  = 12'd1750;
	localparam logic [SAMPLE_W-1:0] RST_REDUCE_HIGH_LEVEL = 12'd1850;
	localparam logic [TIME_W-1:0]   RST_STARTUP_WINDOW_MS = 16'd5000;
	localparam logic [TIME_W-1:0]   RST_OFF_DELAY_MS      = 16'd3000;

	// mode codes as seen on the result
	localparam logic [1:0] MODE_CODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_CODE_ON    = 2'd1;
	localparam logic [1:0] MODE_CODE_PDOWN = 2'd2;

	typedef enum logic [2:0] {
		MODE_OFF   = 3'b001,
		MODE_ON    = 3'b010,
		MODE_PDOWN = 3'b100
	} mode_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] voltage_sample;
		logic [TICK_W-1:0]   now_ms;
	} ivp_in_t;

	typedef struct packed {
		logic       reduce_power;
		logic       voltage_normal;
		logic [1:0] mode;
	} ivp_out_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] off_level;
		logic [SAMPLE_W-1:0] startup_on_level;
		logic [SAMPLE_W-1:0] restore_level;
		logic [SAMPLE_W-1:0] reduce_low_level;
		logic [SAMPLE_W-1:0] reduce_high_level;
		logic [TIME_W-1:0]   startup_window_ms;
		logic [TIME_W-1:0]   off_delay_ms;
	} ivp_cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic              startup_over;
		logic              off_wait_done;
		logic              first_check;
		logic [TICK_W-1:0] mark_time;
		logic              reduce_flag;
		logic              normal_flag;
	} ivp_state_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		case (m)
			MODE_ON:    c = MODE_CODE_ON;
			MODE_PDOWN: c = MODE_CODE_PDOWN;
			default:    c = MODE_CODE_OFF;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/ivp_step.sv */
// ----------------------------------------------------------------------------
// ivp_step
// Next-state logic for one protection check: elapsed time, startup window,
// mode moves with hysteresis and the power-down and normal flags.
// ----------------------------------------------------------------------------
module ivp_step (
	input  ivp_pkg::ivp_cfg_t            cfg,
	input  ivp_pkg::ivp_state_t          cur,
	input  ivp_pkg::ivp_in_t             beat,
	output ivp_pkg::ivp_state_t          nxt
);

	logic [ivp_pkg::TICK_W-1:0]   elapsed;
	logic [ivp_pkg::SAMPLE_W-1:0] v;
	logic [ivp_pkg::SAMPLE_W-1:0] on_level;
	logic                         win_done;
	logic                         delay_done;
	ivp_pkg::ivp_state_t          pre;

	assign v          = beat.voltage_sample;
	assign elapsed    = beat.now_ms - cur.mark_time;
	assign win_done   = elapsed >= {{(ivp_pkg::TICK_W-ivp_pkg::TIME_W){1'b0}},
	                                cfg.startup_window_ms};
	assign delay_done = elapsed >= {{(ivp_pkg::TICK_W-ivp_pkg::TIME_W){1'b0}},
	                                cfg.off_delay_ms};

	always_comb begin
		pre = cur;
		if (cur.first_check) begin
			pre.mark_time     = beat.now_ms;
			pre.off_wait_done = 1'b1;
			pre.first_check   = 1'b0;
		end
		if (win_done) begin
			pre.startup_over = 1'b1;
		end
	end

	assign on_level = pre.startup_over ? cfg.restore_level : cfg.startup_on_level;

	always_comb begin
		nxt = pre;
		case (pre.mode)
			ivp_pkg::MODE_OFF: begin
				if (!pre.off_wait_done) begin
					if (delay_done) begin
						nxt.normal_flag   = 1'b0;
						nxt.off_wait_done = 1'b1;
					end
					if (v > cfg.restore_level) begin
						nxt.mode      = ivp_pkg::MODE_ON;
						nxt.mark_time = beat.now_ms;
					end
				end else if (v > on_level) begin
					nxt.mode          = ivp_pkg::MODE_ON;
					nxt.mark_time     = beat.now_ms;
					nxt.off_wait_done = 1'b0;
				end
			end
			ivp_pkg::MODE_ON: begin
				nxt.reduce_flag = 1'b0;
				nxt.normal_flag = 1'b1;
				if (v < cfg.off_level) begin
					nxt.startup_over  = 1'b1;
					nxt.mode          = ivp_pkg::MODE_OFF;
					nxt.mark_time     = beat.now_ms;
					nxt.off_wait_done = 1'b0;
				end else if (v > cfg.reduce_low_level && v < cfg.reduce_high_level) begin
					nxt.mode      = ivp_pkg::MODE_PDOWN;
					nxt.mark_time = beat.now_ms;
				end
			end
			ivp_pkg::MODE_PDOWN: begin
				nxt.reduce_flag = 1'b1;
				if (v > cfg.restore_level) begin
					nxt.mode      = ivp_pkg::MODE_ON;
					nxt.mark_time = beat.now_ms;
				end else if (v < cfg.off_level) begin
					nxt.mode          = ivp_pkg::MODE_OFF;
					nxt.mark_time     = beat.now_ms;
					nxt.off_wait_done = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/input_voltage_protection_fsm.sv */
// ----------------------------------------------------------------------------
// input_voltage_protection_fsm
// Input-voltage protection: one result beat per sample beat giving the
// power-down flag, the normal flag and the mode after the check.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  in_data   (voltage_sample, now_ms)
//   out      out_valid/out_stall out_data (reduce_power, voltage_normal, mode)
//   cfg      cfg_we             cfg_index, cfg_data
//
// A sample beat is registered, checked from the input register and its
// result registered; one beat per cycle sustained while out_stall is low.
// The rate is set by the state update loop on the mode state.
// Reset clears the mode state and restores all register reset levels.
// A stalled result holds the checker; in_stall rises only when the input
// register is full and its result cannot move on.
// ----------------------------------------------------------------------------
module input_voltage_protection_fsm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ivp_pkg::ivp_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ivp_pkg::ivp_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [ivp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ivp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ivp_pkg::ivp_cfg_t   cfg_q;
	ivp_pkg::ivp_state_t state_q;
	ivp_pkg::ivp_state_t state_nxt;
	ivp_pkg::ivp_in_t    data_s1;
	logic                valid_s1;
	ivp_pkg::ivp_out_t   out_q;
	logic                out_valid_q;
	logic                adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_level         <= ivp_pkg::RST_OFF_LEVEL;
			cfg_q.startup_on_level  <= ivp_pkg::RST_STARTUP_ON_LEVEL;
			cfg_q.restore_level     <= ivp_pkg::RST_RESTORE_LEVEL;
			cfg_q.reduce_low_level  <= ivp_pkg::RST_REDUCE_LOW_LEVEL;
			cfg_q.reduce_high_level <= ivp_pkg::RST_REDUCE_HIGH_LEVEL;
			cfg_q.startup_window_ms <= ivp_pkg::RST_STARTUP_WINDOW_MS;
			cfg_q.off_delay_ms      <= ivp_pkg::RST_OFF_DELAY_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				ivp_pkg::CFG_OFF_LEVEL:
					cfg_q.off_level <= cfg_data[ivp_pkg::SAMPLE_W-1:0];
				ivp_pkg::CFG_STARTUP_ON_LEVEL:
					cfg_q.startup_on_level <= cfg_data[ivp_pkg::SAMPLE_W-1:0];
				ivp_pkg::CFG_RESTORE_LEVEL:
					cfg_q.restore_level <= cfg_data[ivp_pkg::SAMPLE_W-1:0];
				ivp_pkg::CFG_REDUCE_LOW_LEVEL:
					cfg_q.reduce_low_level <= cfg_data[ivp_pkg::SAMPLE_W-1:0];
				ivp_pkg::CFG_REDUCE_HIGH_LEVEL:
					cfg_q.reduce_high_level <= cfg_data[ivp_pkg::SAMPLE_W-1:0];
				ivp_pkg::CFG_STARTUP_WINDOW_MS:
					cfg_q.startup_window_ms <= cfg_data[ivp_pkg::TIME_W-1:0];
				ivp_pkg::CFG_OFF_DELAY_MS:
					cfg_q.off_delay_ms <= cfg_data[ivp_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	ivp_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.beat (data_s1),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= ivp_pkg::MODE_OFF;
			state_q.startup_over  <= 1'b0;
			state_q.off_wait_done <= 1'b0;
			state_q.first_check   <= 1'b1;
			state_q.mark_time     <= '0;
			state_q.reduce_flag   <= 1'b0;
			state_q.normal_flag   <= 1'b1;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.reduce_power   <= state_nxt.reduce_flag;
			out_q.voltage_normal <= state_nxt.normal_flag;
			out_q.mode           <= ivp_pkg::mode_code(state_nxt.mode);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced beat did not reach the result register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result beat changed");

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.mode))
		else $error("mode state not one-hot");

	a_first_check: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q.first_check) |-> $past(adv))
		else $error("first check cleared without a beat");

endmodule

/* sim/ivp_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivp_result_checker
// Watches the sample, result and register-write ports of the input-voltage
// protection block. Keeps its own copy of the thresholds and mode state,
// works out the status each accepted sample beat must produce, and compares
// every accepted result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module ivp_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  ivp_pkg::ivp_in_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  ivp_pkg::ivp_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [ivp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ivp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);

	ivp_pkg::ivp_cfg_t          levels;
	logic [1:0]                 lamp_mode;
	logic                       window_closed;
	logic                       off_timer_done;
	logic                       awaiting_first;
	logic [ivp_pkg::TICK_W-1:0] mark_ms;
	logic                       reduce_now;
	logic                       normal_now;
	ivp_pkg::ivp_out_t          status_due[$];

	function automatic void store_level(input logic [ivp_pkg::CFG_IDX_W-1:0] idx,
			input logic [ivp_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			ivp_pkg::CFG_OFF_LEVEL:
				levels.off_level = val[ivp_pkg::SAMPLE_W-1:0];
			ivp_pkg::CFG_STARTUP_ON_LEVEL:
				levels.startup_on_level = val[ivp_pkg::SAMPLE_W-1:0];
			ivp_pkg::CFG_RESTORE_LEVEL:
				levels.restore_level = val[ivp_pkg::SAMPLE_W-1:0];
			ivp_pkg::CFG_REDUCE_LOW_LEVEL:
				levels.reduce_low_level = val[ivp_pkg::SAMPLE_W-1:0];
			ivp_pkg::CFG_REDUCE_HIGH_LEVEL:
				levels.reduce_high_level = val[ivp_pkg::SAMPLE_W-1:0];
			ivp_pkg::CFG_STARTUP_WINDOW_MS:
				levels.startup_window_ms = val[ivp_pkg::TIME_W-1:0];
			ivp_pkg::CFG_OFF_DELAY_MS:
				levels.off_delay_ms = val[ivp_pkg::TIME_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void enter_off(input logic [ivp_pkg::TICK_W-1:0] now);
		lamp_mode = ivp_pkg::MODE_CODE_OFF;
		mark_ms = now;
		off_timer_done = 1'b0;
	endfunction

	function automatic ivp_pkg::ivp_out_t protect_step(input ivp_pkg::ivp_in_t s);
		logic [ivp_pkg::TICK_W-1:0]   elapsed;
		logic [ivp_pkg::TICK_W-1:0]   window_ticks;
		logic [ivp_pkg::TICK_W-1:0]   delay_ticks;
		logic [ivp_pkg::SAMPLE_W-1:0] turn_on;
		ivp_pkg::ivp_out_t            r;
		elapsed = s.now_ms - mark_ms;
		window_ticks = {{(ivp_pkg::TICK_W-ivp_pkg::TIME_W){1'b0}},
			levels.startup_window_ms};
		delay_ticks = {{(ivp_pkg::TICK_W-ivp_pkg::TIME_W){1'b0}}, levels.off_delay_ms};
		if (awaiting_first) begin
			mark_ms = s.now_ms;
			off_timer_done = 1'b1;
			awaiting_first = 1'b0;
		end
		if (!window_closed && elapsed >= window_ticks)
			window_closed = 1'b1;
		case (lamp_mode)
			ivp_pkg::MODE_CODE_OFF: begin
				if (!off_timer_done) begin
					if (elapsed >= delay_ticks) begin
						normal_now = 1'b0;
						off_timer_done = 1'b1;
					end
					if (s.voltage_sample > levels.restore_level) begin
						lamp_mode = ivp_pkg::MODE_CODE_ON;
						mark_ms = s.now_ms;
					end
				end else begin
					turn_on = window_closed ? levels.restore_level : levels.startup_on_level;
					if (s.voltage_sample > turn_on) begin
						lamp_mode = ivp_pkg::MODE_CODE_ON;
						mark_ms = s.now_ms;
						off_timer_done = 1'b0;
					end
				end
			end
			ivp_pkg::MODE_CODE_ON: begin
				reduce_now = 1'b0;
				normal_now = 1'b1;
				if (s.voltage_sample < levels.off_level) begin
					window_closed = 1'b1;
					enter_off(s.now_ms);
				end else if (s.voltage_sample > levels.reduce_low_level &&
						s.voltage_sample < levels.reduce_high_level) begin
					lamp_mode = ivp_pkg::MODE_CODE_PDOWN;
					mark_ms = s.now_ms;
				end
			end
			ivp_pkg::MODE_CODE_PDOWN: begin
				reduce_now = 1'b1;
				if (s.voltage_sample > levels.restore_level) begin
					lamp_mode = ivp_pkg::MODE_CODE_ON;
					mark_ms = s.now_ms;
				end else if (s.voltage_sample < levels.off_level) begin
					enter_off(s.now_ms);
				end
			end
			default: ;
		endcase
		r.reduce_power = reduce_now;
		r.voltage_normal = normal_now;
		r.mode = lamp_mode;
		return r;
	endfunction

	function automatic void compare_field(input string field, input logic [1:0] want,
			input logic [1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ivp_pkg::ivp_out_t want;
		if (!arst_n) begin
			levels.off_level = ivp_pkg::RST_OFF_LEVEL;
			levels.startup_on_level = ivp_pkg::RST_STARTUP_ON_LEVEL;
			levels.restore_level = ivp_pkg::RST_RESTORE_LEVEL;
			levels.reduce_low_level = ivp_pkg::RST_REDUCE_LOW_LEVEL;
			levels.reduce_high_level = ivp_pkg::RST_REDUCE_HIGH_LEVEL;
			levels.startup_window_ms = ivp_pkg::RST_STARTUP_WINDOW_MS;
			levels.off_delay_ms = ivp_pkg::RST_OFF_DELAY_MS;
			lamp_mode = ivp_pkg::MODE_CODE_OFF;
			window_closed = 1'b0;
			off_timer_done = 1'b0;
			awaiting_first = 1'b1;
			mark_ms = '0;
			reduce_now = 1'b0;
			normal_now = 1'b1;
			status_due.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we)
				store_level(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none due, got reduce %0b normal %0b mode %0d",
						$time, out_data.reduce_power, out_data.voltage_normal, out_data.mode);
				end else begin
					want = status_due.pop_front();
					compare_field("reduce_power", 2'(want.reduce_power),
						2'(out_data.reduce_power));
					compare_field("voltage_normal", 2'(want.voltage_normal),
						2'(out_data.voltage_normal));
					compare_field("mode", want.mode, out_data.mode);
					checked++;
				end
			end
			if (in_valid && !in_stall)
				status_due.push_back(protect_step(in_data));
			pending = status_due.size();
		end
	end

endmodule

/* sim/input_voltage_protection_fsm_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_voltage_protection_fsm_tb
// Drives sample beats and register writes into the protection block and
// throttles its result port. A directed walk covers the mode transitions,
// the startup window, the off delay and tick wraparound; random beats near
// the thresholds follow under several register settings, including the
// all-zero and all-ones extremes. The checker beside the block does the
// comparison; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module input_voltage_protection_fsm_tb;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int MAX_GAP         = 8;
	localparam int HOLD_CYCLES     = 40;
	localparam int SETTLE_CYCLES   = 4;
	localparam int END_CYCLES      = 8;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam logic [ivp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	ivp_pkg::ivp_in_t               in_data;
	logic                           out_valid;
	logic                           out_stall;
	ivp_pkg::ivp_out_t              out_data;
	logic                           cfg_we;
	logic [ivp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ivp_pkg::CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int checked;

	ivp_pkg::ivp_cfg_t          levels;
	logic [ivp_pkg::TICK_W-1:0] tick;
	logic                       no_idle;
	logic                       hold_req;
	logic                       window_by_time;
	int                         samples_sent;
	int                         settings_used;
	int                         holds_done;
	int                         quiet_cycles;
	int                         stall_left;
	logic                       took;

	always #(CLK_PERIOD / 2) clk = ~clk;

	input_voltage_protection_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ivp_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// result side: draw a stall after every accepted beat, or hold off on request
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			took = out_valid && !out_stall;
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
				holds_done++;
			end else if (took) begin
				stall_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("FAIL input_voltage_protection_fsm");
			$finish;
		end
	end

	task automatic send_sample(input logic [ivp_pkg::SAMPLE_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{voltage_sample: v, now_ms: tick};
		do @(posedge clk); while (in_stall);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_after(input int unsigned dt,
			input logic [ivp_pkg::SAMPLE_W-1:0] v);
		tick = tick + dt;
		send_sample(v);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ivp_pkg::CFG_IDX_W-1:0] idx,
			input logic [ivp_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// upper bits of the 12-bit levels carry junk that must be dropped
	task automatic apply_levels(input ivp_pkg::ivp_cfg_t c, input bit stray);
		wait_idle();
		write_reg(ivp_pkg::CFG_OFF_LEVEL, {4'($urandom), c.off_level});
		write_reg(ivp_pkg::CFG_STARTUP_ON_LEVEL, {4'($urandom), c.startup_on_level});
		write_reg(ivp_pkg::CFG_RESTORE_LEVEL, {4'($urandom), c.restore_level});
		write_reg(ivp_pkg::CFG_REDUCE_LOW_LEVEL, {4'($urandom), c.reduce_low_level});
		write_reg(ivp_pkg::CFG_REDUCE_HIGH_LEVEL, {4'($urandom), c.reduce_high_level});
		write_reg(ivp_pkg::CFG_STARTUP_WINDOW_MS, c.startup_window_ms);
		write_reg(ivp_pkg::CFG_OFF_DELAY_MS, c.off_delay_ms);
		if (stray)
			write_reg(CFG_UNUSED_IDX, 16'($urandom));
		cfg_we <= 1'b0;
		levels = c;
		settings_used++;
	endtask

	function automatic logic [ivp_pkg::SAMPLE_W-1:0] near(
			input logic [ivp_pkg::SAMPLE_W-1:0] lvl);
		int n;
		n = int'(lvl) + int'($urandom_range(0, 4)) - 2;
		if (n < 0)
			n = 0;
		if (n > 4095)
			n = 4095;
		return n[ivp_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic logic [ivp_pkg::SAMPLE_W-1:0] pick_sample();
		logic [ivp_pkg::SAMPLE_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 12'($urandom_range(0, 4095));
			1: v = near(levels.off_level);
			2: v = near(levels.restore_level);
			3: v = near(levels.startup_on_level);
			4: begin
				if (int'(levels.reduce_high_level) > int'(levels.reduce_low_level) + 1)
					v = 12'($urandom_range(int'(levels.reduce_low_level) + 1,
						int'(levels.reduce_high_level) - 1));
				else
					v = near(levels.reduce_low_level);
			end
			5: v = near(levels.reduce_high_level);
			6: v = $urandom_range(0, 1) ? '1 : '0;
			default: v = near(levels.reduce_low_level);
		endcase
		return v;
	endfunction

	task automatic advance_tick();
		case ($urandom_range(0, 11))
			0: ;
			1: tick = tick + $urandom;
			2: tick = tick + int'(levels.off_delay_ms) + $urandom_range(0, 2) - 1;
			3: tick = tick + int'(levels.startup_window_ms) + $urandom_range(0, 2) - 1;
			default: tick = tick + $urandom_range(1, 900);
		endcase
	endtask

	task automatic random_samples(input int n);
		repeat (n) begin
			advance_tick();
			send_sample(pick_sample());
		end
	endtask

	function automatic ivp_pkg::ivp_cfg_t reset_levels();
		ivp_pkg::ivp_cfg_t c;
		c.off_level = ivp_pkg::RST_OFF_LEVEL;
		c.startup_on_level = ivp_pkg::RST_STARTUP_ON_LEVEL;
		c.restore_level = ivp_pkg::RST_RESTORE_LEVEL;
		c.reduce_low_level = ivp_pkg::RST_REDUCE_LOW_LEVEL;
		c.reduce_high_level = ivp_pkg::RST_REDUCE_HIGH_LEVEL;
		c.startup_window_ms = ivp_pkg::RST_STARTUP_WINDOW_MS;
		c.off_delay_ms = ivp_pkg::RST_OFF_DELAY_MS;
		return c;
	endfunction

	function automatic ivp_pkg::ivp_cfg_t ordered_levels();
		ivp_pkg::ivp_cfg_t c;
		c.off_level = 12'($urandom_range(1400, 1800));
		c.startup_on_level = c.off_level - 12'($urandom_range(0, 100));
		c.reduce_low_level = c.off_level + 12'($urandom_range(0, 100));
		c.reduce_high_level = c.reduce_low_level + 12'($urandom_range(2, 200));
		c.restore_level = c.reduce_high_level + 12'($urandom_range(0, 300));
		c.startup_window_ms = 16'($urandom_range(500, 8000));
		c.off_delay_ms = 16'($urandom_range(200, 5000));
		return c;
	endfunction

	function automatic ivp_pkg::ivp_cfg_t scrambled_levels();
		ivp_pkg::ivp_cfg_t c;
		c.off_level = 12'($urandom_range(0, 4095));
		c.startup_on_level = 12'($urandom_range(0, 4095));
		c.restore_level = 12'($urandom_range(0, 4095));
		c.reduce_low_level = 12'($urandom_range(0, 4095));
		c.reduce_high_level = 12'($urandom_range(0, 4095));
		c.startup_window_ms = 16'($urandom_range(0, 4000));
		c.off_delay_ms = 16'($urandom_range(0, 4000));
		return c;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		tick = '0;
		samples_sent = 0;
		settings_used = 1;
		holds_done = 0;
		levels = reset_levels();
		window_by_time = 1'($urandom_range(0, 1));
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first check, startup level, band, power-down and restore
		send_after(100, 12'd1660);
		send_after(100, 12'd1800);
		send_after(100, 12'd1800);
		send_after(100, 12'd2101);
		// the startup window closes only once: by time or by a drop from on
		if (window_by_time) begin
			send_after(5000, 12'd1850);
			send_after(100, 12'd1699);
		end else begin
			send_after(100, 12'd1850);
			send_after(100, 12'd1699);
		end
		send_after(100, 12'd4095);
		send_after(100, 12'd0);
		send_after(2999, 12'd2100);
		send_after(1, 12'd1000);
		send_after(100, 12'd2100);
		send_after(100, 12'd2101);
		send_after(100, 12'd1750);
		send_after(100, 12'd1849);
		send_after(100, 12'd1700);
		send_after(100, 12'd2100);
		send_after(100, 12'd1699);
		tick = '1;
		send_sample(12'd2101);
		tick = '0;
		send_sample(12'd1000);
		send_after(2, 12'd4095);

		random_samples(30);
		no_idle = 1'b1;
		random_samples(20);
		no_idle = 1'b0;

		apply_levels('{default: '0}, 1'b0);
		random_samples(50);

		apply_levels('{default: '1}, 1'b1);
		random_samples(40);

		apply_levels(ordered_levels(), 1'b0);
		random_samples(25);
		hold_req = 1'b1;
		no_idle = 1'b1;
		random_samples(12);
		no_idle = 1'b0;
		wait_idle();
		random_samples(25);

		apply_levels(scrambled_levels(), 1'b1);
		random_samples(60);

		apply_levels(scrambled_levels(), 1'b0);
		no_idle = 1'b1;
		random_samples(30);
		no_idle = 1'b0;
		random_samples(30);

		apply_levels(reset_levels(), 1'b0);
		random_samples(50);

		wait_idle();
		repeat (END_CYCLES) @(negedge clk);
		$display("covered %0d sample beats under %0d register settings, %0d long output holds",
			samples_sent, settings_used, holds_done);
		$display("%0d results compared; startup window closed %s",
			checked, window_by_time ? "by elapsed time" : "by a drop from on");
		if (fail_count == 0 && pending == 0) begin
			$display("PASS input_voltage_protection_fsm");
		end else begin
			if (pending != 0)
				$display("%0t: %0d results never arrived", $time, pending);
			$display("FAIL input_voltage_protection_fsm");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ivp_pkg.sv
rtl/core/ivp_step.sv
rtl/core/input_voltage_protection_fsm.sv
sim/ivp_result_checker.sv
sim/input_voltage_protection_fsm_tb.sv
